// ===== rtl/tbrm_pkg.sv =====
// Shared types and constants of the tiny byte register machine.
// No dependencies; the interfaces, the program store and the top level use it.
package tbrm_pkg;

	localparam int PROG_BYTES = 256;
	localparam int NUM_REGS   = 16;
	localparam int PROG_AW    = (PROG_BYTES > 1) ? $clog2(PROG_BYTES) : 1;
	localparam int REG_AW     = $clog2(NUM_REGS);

	typedef logic [7:0] byte_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	typedef enum logic [7:0] {
		OP_INC      = 8'h01,
		OP_DEC      = 8'h02,
		OP_MOV      = 8'h03,
		OP_LDI      = 8'h04,
		OP_SHL      = 8'h05,
		OP_SHR      = 8'h06,
		OP_JMP      = 8'h07,
		OP_JCLR     = 8'h08,
		OP_JSET     = 8'h09,
		OP_JSET_ALT = 8'h0A,
		OP_HALT     = 8'h0B,
		OP_ADD      = 8'h0C,
		OP_SUB      = 8'h0D,
		OP_XOR      = 8'h0E,
		OP_OR       = 8'h0F,
		OP_READ     = 8'h10,
		OP_OUT      = 8'h11
	} opcode_t;

	// write port of the program store
	typedef struct packed {
		logic  en;
		byte_t addr;
		byte_t data;
	} store_wr_t;

	// instruction bytes at the program counter
	typedef struct packed {
		byte_t op;
		byte_t par;
	} fetch_t;

endpackage

// ===== rtl/tbrm_item_if.sv =====
// Input channel of the machine: handshake plus one item's fields.
// Depends on tbrm_pkg.
interface tbrm_item_if;
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	tbrm_pkg::byte_t       prog_addr;
	tbrm_pkg::byte_t       prog_byte;
	tbrm_pkg::byte_t       in_byte;
	logic                  in_end;

	modport source(output valid, cmd, prog_addr, prog_byte, in_byte, in_end, input ready);
	modport sink(input valid, cmd, prog_addr, prog_byte, in_byte, in_end, output ready);
endinterface

// ===== rtl/tbrm_result_if.sv =====
// Result channel of the machine: handshake plus one result's fields.
// Depends on tbrm_pkg.
interface tbrm_result_if;
	logic                  valid;
	logic                  ready;
	logic                  out_valid;
	tbrm_pkg::byte_t       out_byte;
	logic                  in_taken;
	logic                  halted;
	tbrm_pkg::byte_t       next_pc;

	modport source(output valid, out_valid, out_byte, in_taken, halted, next_pc, input ready);
	modport sink(input valid, out_valid, out_byte, in_taken, halted, next_pc, output ready);
endinterface

// ===== rtl/tiny_byte_register_machine.sv =====
// Top level of the tiny byte register machine.
// Depends on tbrm_pkg, tbrm_item_if, tbrm_result_if and tbrm_prog_store.
//
// Usage:
//   item   (sink)   : one beat per item. cmd CMD_LOAD writes prog_byte at
//                     prog_addr; cmd CMD_STEP executes the two-byte
//                     instruction at the program counter, offering in_byte /
//                     in_end to a read instruction.
//   result (source) : exactly one beat per item, in order, carrying
//                     out_valid/out_byte, in_taken, halted and next_pc.
//   Path: an item taken passes from the input register, through execute,
//   into the result register.
//   Throughput: one item per cycle while the result beat is taken; the
//   program store is read ahead at the next program counter and the register
//   file is in flops, so an instruction executes as its item leaves the input register.
//   Stall: while the result register is full and not taken, the item in the
//   input register holds and item.ready drops; nothing is lost.
//   Reset: registers, flag, program counter and halt state clear; the whole
//   program store reads as zero until written.
module tiny_byte_register_machine (
	input  logic           clk,
	input  logic           arst_n,
	tbrm_item_if.sink      item,
	tbrm_result_if.source  result
);

	typedef struct packed {
		logic            cmd;
		tbrm_pkg::byte_t prog_addr;
		tbrm_pkg::byte_t prog_byte;
		tbrm_pkg::byte_t in_byte;
		logic            in_end;
	} item_t;

	typedef struct packed {
		logic            out_valid;
		tbrm_pkg::byte_t out_byte;
		logic            in_taken;
		logic            halted;
		tbrm_pkg::byte_t next_pc;
	} res_t;

	logic  s1_valid_q;
	item_t item_s1;
	logic  res_valid_q;
	res_t  res_q;

	tbrm_pkg::byte_t regs_q [tbrm_pkg::NUM_REGS];
	tbrm_pkg::byte_t pc_q;
	logic            flag_q;
	logic            halted_q;

	logic                 adv, acc, step;
	tbrm_pkg::fetch_t     fetch;
	tbrm_pkg::store_wr_t  store_wr;
	tbrm_pkg::byte_t      fetch_addr;
	logic [tbrm_pkg::REG_AW-1:0] rd, rs;
	tbrm_pkg::byte_t      a, b;

	logic                        reg_we;
	logic [tbrm_pkg::REG_AW-1:0] reg_wa;
	tbrm_pkg::byte_t             reg_wd;
	tbrm_pkg::byte_t             pc_new;
	logic                        flag_new, halt_new;
	logic                        ovalid, taken;
	tbrm_pkg::byte_t             obyte;
	res_t                        res_new;

	// handshake: the input register advances when the result register frees up
	assign adv        = s1_valid_q && (!res_valid_q || result.ready);
	assign item.ready = !s1_valid_q || adv;
	assign acc        = item.valid && item.ready;
	assign step       = adv && (item_s1.cmd == tbrm_pkg::CMD_STEP) && !halted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= '{cmd: item.cmd, prog_addr: item.prog_addr,
				prog_byte: item.prog_byte, in_byte: item.in_byte, in_end: item.in_end};
		end
	end

	// program store, fetched ahead at the program counter to come
	always_comb begin
		store_wr.en   = adv && (item_s1.cmd == tbrm_pkg::CMD_LOAD);
		store_wr.addr = item_s1.prog_addr;
		store_wr.data = item_s1.prog_byte;
	end

	assign fetch_addr = step ? pc_new : pc_q;

	tbrm_prog_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (store_wr),
		.fetch_addr (fetch_addr),
		.fetch      (fetch)
	);

	assign rd = fetch.par[tbrm_pkg::REG_AW-1:0];
	assign rs = fetch.par[7:4];
	assign a  = regs_q[rd];
	assign b  = regs_q[rs];

	// execute one instruction
	always_comb begin
		reg_we   = 1'b0;
		reg_wa   = rd;
		reg_wd   = a;
		pc_new   = pc_q + 8'd2;
		flag_new = flag_q;
		halt_new = 1'b0;
		ovalid   = 1'b0;
		taken    = 1'b0;
		obyte    = 8'd0;
		case (fetch.op)
			tbrm_pkg::OP_INC: begin
				reg_we = 1'b1;
				reg_wd = a + 8'd1;
			end
			tbrm_pkg::OP_DEC: begin
				reg_we = 1'b1;
				reg_wd = a - 8'd1;
			end
			tbrm_pkg::OP_MOV: begin
				reg_we = 1'b1;
				reg_wd = b;
			end
			tbrm_pkg::OP_LDI: begin
				reg_we = 1'b1;
				reg_wa = '0;
				reg_wd = fetch.par;
			end
			tbrm_pkg::OP_SHL: begin
				reg_we = 1'b1;
				reg_wd = {a[6:0], 1'b0};
			end
			tbrm_pkg::OP_SHR: begin
				reg_we = 1'b1;
				reg_wd = {1'b0, a[7:1]};
			end
			tbrm_pkg::OP_JMP: begin
				pc_new = pc_q + fetch.par;
			end
			tbrm_pkg::OP_JCLR: begin
				if (!flag_q) begin
					pc_new = pc_q + fetch.par;
				end
			end
			tbrm_pkg::OP_JSET, tbrm_pkg::OP_JSET_ALT: begin
				if (flag_q) begin
					pc_new = pc_q + fetch.par;
				end
			end
			tbrm_pkg::OP_HALT: begin
				halt_new = 1'b1;
				pc_new   = pc_q;
			end
			tbrm_pkg::OP_ADD: begin
				reg_we = 1'b1;
				reg_wd = a + b;
			end
			tbrm_pkg::OP_SUB: begin
				reg_we = 1'b1;
				reg_wd = a - b;
			end
			tbrm_pkg::OP_XOR: begin
				reg_we = 1'b1;
				reg_wd = a ^ b;
			end
			tbrm_pkg::OP_OR: begin
				reg_we = 1'b1;
				reg_wd = a | b;
			end
			tbrm_pkg::OP_READ: begin
				if (item_s1.in_end) begin
					flag_new = 1'b1;
				end else begin
					flag_new = 1'b0;
					reg_we   = 1'b1;
					reg_wd   = item_s1.in_byte;
					taken    = 1'b1;
				end
			end
			tbrm_pkg::OP_OUT: begin
				ovalid = 1'b1;
				obyte  = a;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tbrm_pkg::NUM_REGS; i++) begin
				regs_q[i] <= 8'd0;
			end
			pc_q     <= 8'd0;
			flag_q   <= 1'b0;
			halted_q <= 1'b0;
		end else if (step) begin
			if (reg_we) begin
				regs_q[reg_wa] <= reg_wd;
			end
			pc_q     <= pc_new;
			flag_q   <= flag_new;
			halted_q <= halt_new;
		end
	end

	// result beat: loads and halted steps report state only
	always_comb begin
		if (step) begin
			res_new = '{out_valid: ovalid, out_byte: obyte, in_taken: taken,
				halted: halt_new, next_pc: pc_new};
		end else begin
			res_new = '{out_valid: 1'b0, out_byte: 8'd0, in_taken: 1'b0,
				halted: halted_q, next_pc: pc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_new;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.out_valid = res_q.out_valid;
	assign result.out_byte  = res_q.out_byte;
	assign result.in_taken  = res_q.in_taken;
	assign result.halted    = res_q.halted;
	assign result.next_pc   = res_q.next_pc;

	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pc_q) && $stable(flag_q))
		else $error("machine state moved without an executed step");

	assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q && $stable(pc_q))
		else $error("machine left the halted state");

	assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> s1_valid_q && res_valid_q && !result.ready)
		else $error("input stalled without a stalled result");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_q && (res_q.next_pc == pc_q) && (res_q.halted == halted_q))
		else $error("result does not report the state after its item");

endmodule

// ===== rtl/tbrm_prog_store.sv =====
// Program store: byte memory with per-entry valid bits and a registered
// two-byte fetch at the address given for the next cycle. Depends on tbrm_pkg.
module tbrm_prog_store (
	input  logic                clk,
	input  logic                arst_n,
	input  tbrm_pkg::store_wr_t wr,
	input  tbrm_pkg::byte_t     fetch_addr,
	output tbrm_pkg::fetch_t    fetch
);

	localparam int AW = tbrm_pkg::PROG_AW;

	tbrm_pkg::byte_t        mem [tbrm_pkg::PROG_BYTES];
	logic [tbrm_pkg::PROG_BYTES-1:0] vld_q;

	tbrm_pkg::byte_t addr0, addr1;
	logic            wr_ok, ok0, ok1;
	logic [AW-1:0]   widx, idx0, idx1;

	tbrm_pkg::byte_t op_mem_q, par_mem_q, byp_data_q;
	logic            op_ok_q, par_ok_q, op_byp_q, par_byp_q;

	assign addr0 = fetch_addr;
	assign addr1 = fetch_addr + 8'd1;
	assign wr_ok = wr.en && ({1'b0, wr.addr} < 9'(tbrm_pkg::PROG_BYTES));
	assign ok0   = {1'b0, addr0} < 9'(tbrm_pkg::PROG_BYTES);
	assign ok1   = {1'b0, addr1} < 9'(tbrm_pkg::PROG_BYTES);
	assign widx  = wr.addr[AW-1:0];
	assign idx0  = addr0[AW-1:0];
	assign idx1  = addr1[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[widx] <= wr.data;
		end
		op_mem_q   <= mem[idx0];
		par_mem_q  <= mem[idx1];
		byp_data_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			op_ok_q   <= 1'b0;
			par_ok_q  <= 1'b0;
			op_byp_q  <= 1'b0;
			par_byp_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				vld_q[widx] <= 1'b1;
			end
			op_ok_q   <= ok0 && vld_q[idx0];
			par_ok_q  <= ok1 && vld_q[idx1];
			// a write to a fetched address this cycle wins over the old contents
			op_byp_q  <= wr_ok && (wr.addr == addr0);
			par_byp_q <= wr_ok && (wr.addr == addr1);
		end
	end

	always_comb begin
		fetch.op  = op_byp_q  ? byp_data_q : (op_ok_q  ? op_mem_q  : 8'd0);
		fetch.par = par_byp_q ? byp_data_q : (par_ok_q ? par_mem_q : 8'd0);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_ok && (wr.addr == addr0) |=> fetch.op == $past(wr.data))
		else $error("fetched opcode misses a same-cycle program write");

	assert property (@(posedge clk) disable iff (!arst_n)
		!op_byp_q && !op_ok_q |-> fetch.op == 8'd0)
		else $error("unwritten program byte does not read as zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_ok |=> vld_q[$past(widx)])
		else $error("program write left its entry marked empty");

endmodule
